/* hw/rtl/tsiprx_pkg.sv */
package tsiprx_pkg;

   // Largest number of unstuffed bytes kept per frame (id byte included).
   localparam int MAX_FRAME_BYTES = 64;
   localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);

   localparam int RX_BYTE_W        = 8;
   localparam int PACKET_ID_W      = 8;
   localparam int PAYLOAD_LENGTH_W = 7;
   localparam int NAV_STATUS_W     = 8;
   localparam int FIX_TYPE_W       = 2;
   localparam int TRACKED_SATS_W   = 4;
   localparam int TIME_OF_WEEK_W   = 20;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 56;

   localparam logic [7:0] DLE_BYTE = 8'h10;
   localparam logic [7:0] ETX_BYTE = 8'h03;

   localparam logic [7:0] ID_HEALTH      = 8'h46;
   localparam logic [7:0] ID_ALL_IN_VIEW = 8'h6d;
   localparam logic [7:0] ID_END_PERIOD  = 8'h82;

   localparam logic [7:0] HEALTH_RESET = 8'hff;
   localparam logic [7:0] HEALTH_OK    = 8'h00;
   localparam logic [2:0] DIM_MASK     = 3'h7;
   localparam logic [2:0] DIM_2D       = 3'd3;
   localparam logic [2:0] DIM_3D       = 3'd4;

   localparam logic [TIME_OF_WEEK_W-1:0] WEEK_SECONDS_RESET = 20'd604800;

   typedef enum logic [1:0] {
      FIX_NONE = 2'd0,
      FIX_2D   = 2'd1,
      FIX_3D   = 2'd2
   } fix_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_AFTER_DLE = 2'd1,
      MODE_IN_FRAME  = 2'd2
   } mode_type;

   typedef struct packed {
      logic                          data_ready;
      logic [TIME_OF_WEEK_W-1:0]     time_of_week;
      logic [TRACKED_SATS_W-1:0]     tracked_sats;
      logic [FIX_TYPE_W-1:0]         fix_type;
      logic [NAV_STATUS_W-1:0]       nav_status;
      logic                          length_overflow;
      logic [PAYLOAD_LENGTH_W-1:0]   payload_length;
      logic [PACKET_ID_W-1:0]        packet_id;
   } result_type;

endpackage

/* hw/rtl/tsip_report_receiver.sv */
// TSIP report receiver. Each request on the req_ channel carries one raw byte from the
// serial line. The block strips TSIP framing: in idle a DLE (0x10) opens a frame, inside a
// frame DLE DLE stands for one data byte, DLE ETX (0x03) closes the frame, and a DLE followed
// by any other byte keeps that byte as data. Every closed frame with at least one byte gives
// one response on the rsp_ channel with its id, its length (saturated at MAX_FRAME_BYTES,
// with an overflow flag) and the receiver status after the frame was decoded: health report
// 0x46 sets the navigation status, all-in-view report 0x6D sets fix type and satellite count,
// and end-of-period report 0x82 advances the time-of-week counter while there is no fix and
// raises data_ready. Empty frames give no response. The counter wraps at the week length held
// in the csr_ register, which should only be written while no byte is in flight. The block
// takes one byte per clock cycle as long as responses are drained; a byte passes an input
// register and the parser logic, and a response is written to the output register when the
// parser advances on the closing ETX. The output register only holds the parser back while a
// response sits there untaken.
module tsip_report_receiver
   import tsiprx_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_W-1:0]    req_tdata,   // [7:0] rx_byte

   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [7:0] packet_id, [14:8] payload_length, [15] length_overflow, [23:16] nav_status,
   // [25:24] fix_type, [29:26] tracked_sats, [49:30] time_of_week, [50] data_ready,
   // [55:51] zero
   output logic [RSP_TDATA_W-1:0]    rsp_tdata,

   input  logic                      csr_we,
   input  logic [TIME_OF_WEEK_W-1:0] csr_wdata   // week_seconds
);

   // Input register.
   logic                 byte_valid_ff;
   logic [RX_BYTE_W-1:0] byte_ff;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff,  rsp_data_in;

   // Configuration.
   logic [TIME_OF_WEEK_W-1:0] week_seconds_ff;

   // Parser and status state.
   mode_type                  mode_ff,   mode_in;
   logic [COUNT_W-1:0]        count_ff,  count_in;
   logic [PACKET_ID_W-1:0]    id_ff,     id_in;
   logic [RX_BYTE_W-1:0]      first_ff,  first_in;
   logic                      ovf_ff,    ovf_in;
   logic [NAV_STATUS_W-1:0]   health_ff, health_in;
   logic [FIX_TYPE_W-1:0]     fix_ff,    fix_in;
   logic [TRACKED_SATS_W-1:0] sats_ff,   sats_in;
   logic [TIME_OF_WEEK_W-1:0] tow_ff,    tow_in;

   logic advance;
   logic store;
   logic close;

   logic [COUNT_W+PAYLOAD_LENGTH_W-1:0] count_wide;
   logic [TIME_OF_WEEK_W-1:0]           tow_inc;
   logic [2:0]                          dim;

   // The parser advances when a byte waits and the output register is free or drained now.
   assign advance    = byte_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !byte_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_tready) begin
         byte_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         byte_ff <= req_tdata[RX_BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         week_seconds_ff <= WEEK_SECONDS_RESET;
      end else if (csr_we) begin
         week_seconds_ff <= csr_wdata;
      end
   end

   // Next parse mode, and whether this byte is data or closes a frame.
   always_comb begin
      mode_in = mode_ff;
      store   = 1'b0;
      close   = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (byte_ff == DLE_BYTE) begin
               mode_in = MODE_AFTER_DLE;
            end
         end
         MODE_AFTER_DLE: begin
            if (byte_ff == ETX_BYTE) begin
               mode_in = MODE_IDLE;
               close   = 1'b1;
            end else begin
               mode_in = MODE_IN_FRAME;
               store   = 1'b1;
            end
         end
         default: begin
            // In frame; an unused code behaves the same way.
            if (byte_ff == DLE_BYTE) begin
               mode_in = MODE_AFTER_DLE;
            end else begin
               mode_in = MODE_IN_FRAME;
               store   = 1'b1;
            end
         end
      endcase
   end

   assign dim     = first_ff[2:0] & DIM_MASK;
   assign tow_inc = tow_ff + TIME_OF_WEEK_W'(1);

   // Frame buffer bookkeeping and report decoding.
   always_comb begin
      count_in  = count_ff;
      id_in     = id_ff;
      first_in  = first_ff;
      ovf_in    = ovf_ff;
      health_in = health_ff;
      fix_in    = fix_ff;
      sats_in   = sats_ff;
      tow_in    = tow_ff;

      // Opening DLE starts a fresh frame.
      if (mode_ff == MODE_IDLE && byte_ff == DLE_BYTE) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end

      if (store) begin
         if (count_ff >= COUNT_W'(MAX_FRAME_BYTES)) begin
            ovf_in = 1'b1;
         end else begin
            if (count_ff == COUNT_W'(0)) begin
               id_in = byte_ff;
            end
            if (count_ff == COUNT_W'(1)) begin
               first_in = byte_ff;
            end
            count_in = count_ff + COUNT_W'(1);
         end
      end

      // Only a frame that holds at least its id byte is decoded.
      if (close && count_ff != '0) begin
         case (id_ff)
            ID_HEALTH: begin
               if (count_ff >= COUNT_W'(2)) begin
                  health_in = first_ff;
               end
            end
            ID_ALL_IN_VIEW: begin
               if (count_ff >= COUNT_W'(2)) begin
                  fix_in = FIX_NONE;
                  if (health_ff == HEALTH_OK) begin
                     if (dim == DIM_2D) begin
                        fix_in = FIX_2D;
                     end else if (dim == DIM_3D) begin
                        fix_in = FIX_3D;
                     end
                  end
                  sats_in = first_ff[7:4];
               end
            end
            ID_END_PERIOD: begin
               // The counter only runs on its own while there is no fix.
               if (fix_ff == FIX_NONE) begin
                  tow_in = (tow_inc >= week_seconds_ff) ? '0 : tow_inc;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign count_wide = (COUNT_W + PAYLOAD_LENGTH_W)'(count_ff);

   // Response built from the status after decoding.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (advance && close && count_ff != '0) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.packet_id       = id_ff;
         rsp_data_in.payload_length  = count_wide[PAYLOAD_LENGTH_W-1:0];
         rsp_data_in.length_overflow = ovf_ff;
         rsp_data_in.nav_status      = health_in;
         rsp_data_in.fix_type        = fix_in;
         rsp_data_in.tracked_sats    = sats_in;
         rsp_data_in.time_of_week    = tow_in;
         rsp_data_in.data_ready      = (id_ff == ID_END_PERIOD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         count_ff     <= '0;
         id_ff        <= '0;
         first_ff     <= '0;
         ovf_ff       <= 1'b0;
         health_ff    <= HEALTH_RESET;
         fix_ff       <= FIX_NONE;
         sats_ff      <= '0;
         tow_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            mode_ff   <= mode_in;
            count_ff  <= count_in;
            id_ff     <= id_in;
            first_ff  <= first_in;
            ovf_ff    <= ovf_in;
            health_ff <= health_in;
            fix_ff    <= fix_in;
            sats_ff   <= sats_in;
            tow_ff    <= tow_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

endmodule
